// ----- rtl/hcbd_pkg.sv -----
// Shared constants, result beat type and hex digit decoder for the chunked body decoder.
package hcbd_pkg;

  localparam int unsigned SIZE_BITS_DEF = 32;
  localparam int unsigned HEX_DIGIT_BITS = 4;

  localparam logic [7:0] ASCII_LF = 8'h0A;
  localparam logic [7:0] ASCII_CR = 8'h0D;
  localparam logic [7:0] ASCII_SP = 8'h20;
  localparam logic [7:0] ASCII_HT = 8'h09;

  typedef struct packed {
    logic                      valid;
    logic [HEX_DIGIT_BITS-1:0] value;
  } hex_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       data_valid;
    logic       chunk_end;
    logic       body_done;
    logic       framing_error;
  } result_t;

  function automatic hex_t hex_decode(input logic [7:0] b);
    hex_t h;
    h.valid = 1'b1;
    h.value = '0;
    if (b >= 8'h30 && b <= 8'h39) begin
      h.value = HEX_DIGIT_BITS'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      h.value = HEX_DIGIT_BITS'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      h.value = HEX_DIGIT_BITS'(b - 8'h37);
    end else begin
      h.valid = 1'b0;
    end
    return h;
  endfunction

endpackage

// ----- rtl/http_chunked_body_decoder.sv -----
// Top level: chunked HTTP body decoder, one raw byte in, one result beat out.
//
//   channel | signals                                 | dir | handshake
//   --------+-----------------------------------------+-----+--------------------
//   in      | in_byte                                 | in  | in_valid / in_ready
//   out     | out_data_byte, out_data_valid,          | out | out_valid / out_ready
//           | out_chunk_end, out_body_done,           |     |
//           | out_framing_error                       |     |
//
// One beat per cycle while in_ready is high: the parse step is a single
// combinational pass from the decoder state registers into a two-entry output
// buffer (result + skid). Accepted results go to the result register, or to skid on a stall.
// in_ready depends only on the skid register, so a held result costs at most
// one extra beat of buffering before the input stalls.
// Synchronous active-low reset returns the parser to seeking a size line.
module http_chunked_body_decoder #(
  parameter int unsigned SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_data_byte,
  output logic       out_data_valid,
  output logic       out_chunk_end,
  output logic       out_body_done,
  output logic       out_framing_error
);

  typedef enum logic [2:0] {
    PH_SEEK   = 3'd0,
    PH_DIGITS = 3'd1,
    PH_EXT    = 3'd2,
    PH_DATA   = 3'd3
  } phase_t;

  localparam int unsigned DB = hcbd_pkg::HEX_DIGIT_BITS;

  phase_t               phase_r, phase_nxt;
  logic [SIZE_BITS-1:0] remaining_r, remaining_nxt;
  logic                 swallow_lf_r, swallow_lf_nxt;
  logic                 error_seen_r, error_seen_nxt;

  hcbd_pkg::result_t    res_nxt;
  hcbd_pkg::result_t    out_r, skid_r;
  logic                 out_vld_r, skid_vld_r;

  hcbd_pkg::hex_t       hex;
  logic                 is_eol, is_ws, in_fire;

  assign in_ready = !skid_vld_r;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    hex            = hcbd_pkg::hex_decode(in_byte);
    is_eol         = (in_byte == hcbd_pkg::ASCII_CR) || (in_byte == hcbd_pkg::ASCII_LF);
    is_ws          = (in_byte == hcbd_pkg::ASCII_SP) || (in_byte == hcbd_pkg::ASCII_HT);
    phase_nxt      = phase_r;
    remaining_nxt  = remaining_r;
    swallow_lf_nxt = swallow_lf_r;
    error_seen_nxt = error_seen_r;
    res_nxt        = '0;
    if (!error_seen_r) begin
      unique case (phase_r)
        PH_SEEK: begin
          swallow_lf_nxt = 1'b0;
          if (!(is_eol || is_ws)) begin
            if (hex.valid) begin
              remaining_nxt = SIZE_BITS'(hex.value);
              phase_nxt     = PH_DIGITS;
            end else begin
              error_seen_nxt = 1'b1;
            end
          end
        end
        PH_DIGITS, PH_EXT: begin
          priority if (phase_r == PH_DIGITS && hex.valid) begin
            if (remaining_r[SIZE_BITS-1 -: DB] != '0) begin
              remaining_nxt = '1;
            end else begin
              remaining_nxt = {remaining_r[SIZE_BITS-DB-1:0], hex.value};
            end
          end else if (is_eol) begin
            if (remaining_r == '0) begin
              res_nxt.body_done = 1'b1;
              phase_nxt         = PH_SEEK;
              swallow_lf_nxt    = 1'b0;
            end else begin
              phase_nxt      = PH_DATA;
              swallow_lf_nxt = (in_byte == hcbd_pkg::ASCII_CR);
            end
          end else begin
            phase_nxt = PH_EXT;
          end
        end
        default: begin
          swallow_lf_nxt = 1'b0;
          if (!(swallow_lf_r && in_byte == hcbd_pkg::ASCII_LF)) begin
            res_nxt.data_byte  = in_byte;
            res_nxt.data_valid = 1'b1;
            if (remaining_r != '0) begin
              remaining_nxt = remaining_r - SIZE_BITS'(1);
            end
            if (remaining_r[SIZE_BITS-1:1] == '0) begin
              res_nxt.chunk_end = 1'b1;
              phase_nxt         = PH_SEEK;
            end
          end
        end
      endcase
    end
    res_nxt.framing_error = error_seen_nxt;
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_SEEK;
      remaining_r  <= '0;
      swallow_lf_r <= 1'b0;
      error_seen_r <= 1'b0;
    end else if (in_fire) begin
      phase_r      <= phase_nxt;
      remaining_r  <= remaining_nxt;
      swallow_lf_r <= swallow_lf_nxt;
      error_seen_r <= error_seen_nxt;
    end
  end

  // output buffer: result register plus skid register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (!out_vld_r || out_ready) begin
      if (skid_vld_r) begin
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end else begin
        out_vld_r <= in_fire;
      end
    end else if (in_fire) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_vld_r || out_ready) begin
      if (skid_vld_r) begin
        out_r <= skid_r;
      end else if (in_fire) begin
        out_r <= res_nxt;
      end
    end else if (in_fire) begin
      skid_r <= res_nxt;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_data_byte     = out_r.data_byte;
  assign out_data_valid    = out_r.data_valid;
  assign out_chunk_end     = out_r.chunk_end;
  assign out_body_done     = out_r.body_done;
  assign out_framing_error = out_r.framing_error;

endmodule

// ----- rtl/hcbd_checker.sv -----
// Port-level checker for the chunked body decoder, bound to the top level.
module hcbd_props (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_data_byte,
  input logic       out_data_valid,
  input logic       out_chunk_end,
  input logic       out_body_done,
  input logic       out_framing_error
);

  logic err_beat_r;

  // an error beat has left the block
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_beat_r <= 1'b0;
    end else if (out_valid && out_ready && out_framing_error) begin
      err_beat_r <= 1'b1;
    end
  end

  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && err_beat_r |-> out_framing_error)
    else $error("framing_error dropped after an error beat");

  a_err_drops: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_framing_error |->
      !out_data_valid && !out_chunk_end && !out_body_done && out_data_byte == 8'h00)
    else $error("beat passed on after framing error");

  a_end_is_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_chunk_end |-> out_data_valid && !out_body_done)
    else $error("chunk_end without payload byte");

  a_done_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_body_done || !out_data_valid) |-> out_data_byte == 8'h00)
    else $error("data byte set on a non-payload beat");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data_byte)
      && $stable(out_data_valid) && $stable(out_chunk_end)
      && $stable(out_body_done) && $stable(out_framing_error))
    else $error("stalled result beat changed");

endmodule

bind http_chunked_body_decoder hcbd_props u_hcbd_props (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_data_byte    (out_data_byte),
  .out_data_valid   (out_data_valid),
  .out_chunk_end    (out_chunk_end),
  .out_body_done    (out_body_done),
  .out_framing_error(out_framing_error)
);
